FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define STL_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define STL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// Source text lexer package
// Widths, token kind codes, character codes and shared types of the lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

	// Sizing of the scan state.
	localparam int KEYWORD_CHARS   = 6;
	localparam int POSITION_BITS   = 32;
	localparam int LENGTH_BITS     = 16;
	localparam int WINDOW_BITS     = 8 * KEYWORD_CHARS;
	localparam int NUM_KEYWORDS    = 10;

	// Widths of the result fields on the ports.
	localparam int KIND_BITS       = 6;
	localparam int START_BITS      = 32;
	localparam int OUT_LENGTH_BITS = 16;

	// Queue depths; both must be powers of two so the pointers wrap by themselves.
	localparam int CMD_DEPTH       = 4;
	localparam int CMD_PTR_BITS    = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_BITS    = $clog2(CMD_DEPTH + 1);
	localparam int RES_DEPTH       = 4;
	localparam int RES_PTR_BITS    = $clog2(RES_DEPTH);
	localparam int RES_CNT_BITS    = $clog2(RES_DEPTH + 1);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	// Token kinds: operators, then keywords, then the other token classes.
	localparam logic [KIND_BITS-1:0] K_LPAREN   = KIND_BITS'(0);
	localparam logic [KIND_BITS-1:0] K_RPAREN   = KIND_BITS'(1);
	localparam logic [KIND_BITS-1:0] K_LBRACKET = KIND_BITS'(2);
	localparam logic [KIND_BITS-1:0] K_RBRACKET = KIND_BITS'(3);
	localparam logic [KIND_BITS-1:0] K_COMMA    = KIND_BITS'(4);
	localparam logic [KIND_BITS-1:0] K_PLUS     = KIND_BITS'(5);
	localparam logic [KIND_BITS-1:0] K_MINUS    = KIND_BITS'(6);
	localparam logic [KIND_BITS-1:0] K_STAR     = KIND_BITS'(7);
	localparam logic [KIND_BITS-1:0] K_SLASH    = KIND_BITS'(8);
	localparam logic [KIND_BITS-1:0] K_PERCENT  = KIND_BITS'(9);
	localparam logic [KIND_BITS-1:0] K_AND_AND  = KIND_BITS'(10);
	localparam logic [KIND_BITS-1:0] K_AMP      = KIND_BITS'(11);
	localparam logic [KIND_BITS-1:0] K_OR_OR    = KIND_BITS'(12);
	localparam logic [KIND_BITS-1:0] K_BAR      = KIND_BITS'(13);
	localparam logic [KIND_BITS-1:0] K_CARET    = KIND_BITS'(14);
	localparam logic [KIND_BITS-1:0] K_EQ_EQ    = KIND_BITS'(15);
	localparam logic [KIND_BITS-1:0] K_ASSIGN   = KIND_BITS'(16);
	localparam logic [KIND_BITS-1:0] K_NOT_EQ   = KIND_BITS'(17);
	localparam logic [KIND_BITS-1:0] K_BANG     = KIND_BITS'(18);
	localparam logic [KIND_BITS-1:0] K_TILDE    = KIND_BITS'(19);
	localparam logic [KIND_BITS-1:0] K_SHL      = KIND_BITS'(20);
	localparam logic [KIND_BITS-1:0] K_LE       = KIND_BITS'(21);
	localparam logic [KIND_BITS-1:0] K_LT       = KIND_BITS'(22);
	localparam logic [KIND_BITS-1:0] K_SHR      = KIND_BITS'(23);
	localparam logic [KIND_BITS-1:0] K_GE       = KIND_BITS'(24);
	localparam logic [KIND_BITS-1:0] K_GT       = KIND_BITS'(25);
	localparam logic [KIND_BITS-1:0] K_KEYWORD0 = KIND_BITS'(26);
	localparam logic [KIND_BITS-1:0] K_STRING   = KIND_BITS'(36);
	localparam logic [KIND_BITS-1:0] K_NUMBER   = KIND_BITS'(37);
	localparam logic [KIND_BITS-1:0] K_NAME     = KIND_BITS'(38);
	localparam logic [KIND_BITS-1:0] K_INVALID  = KIND_BITS'(39);
	localparam logic [KIND_BITS-1:0] K_END      = KIND_BITS'(40);

	// Characters with a role in classification or operator pairing.
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_DIGIT0  = 8'h30;
	localparam logic [7:0] CH_DIGIT9  = 8'h39;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_BAR     = 8'h7C;

	typedef logic [KIND_BITS-1:0]     kind_t;
	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [LENGTH_BITS-1:0]   len_t;

	typedef enum logic [3:0] {
		CL_BLANK,
		CL_NEWLINE,
		CL_SEMI,
		CL_QUOTE,
		CL_DIGIT,
		CL_ALPHA,
		CL_LONE,
		CL_SINGLE,
		CL_OTHER
	} char_class_t;

	// A classified character on its way from the front to the scanner.
	typedef struct packed {
		logic        eot;
		logic [7:0]  ch;
		char_class_t cls;
		kind_t       op_kind;
	} cmd_t;

	// One result entry as it leaves the block.
	typedef struct packed {
		kind_t                      kind;
		logic [START_BITS-1:0]      start;
		logic [OUT_LENGTH_BITS-1:0] length;
		logic                       sat;
		logic                       last;
	} res_t;

	// Up to two result writes per scanned character.
	typedef struct packed {
		logic wr0;
		logic wr1;
		res_t r0;
		res_t r1;
	} res_wr_t;

endpackage

FILE: rtl/stl_front.sv
// ----------------------------------------------------------------------------
// Lexer front end
// Accepts input transactions and tags each character with its class.
// ----------------------------------------------------------------------------
module stl_front import stl_pkg::*; (
	input  logic       push,
	output logic       full,
	input  logic [7:0] ch,
	input  logic       end_of_text,
	input  logic       fifo_full,
	output logic       fifo_wr,
	output cmd_t       cmd
);

	assign full    = fifo_full;
	assign fifo_wr = push & ~fifo_full;

	always_comb begin
		cmd.eot     = end_of_text;
		cmd.ch      = ch;
		cmd.cls     = CL_OTHER;
		cmd.op_kind = K_INVALID;
		priority if (ch == CH_LF) begin
			cmd.cls = CL_NEWLINE;
		end else if (ch == CH_TAB || ch == CH_SPACE || ch == CH_CR) begin
			cmd.cls = CL_BLANK;
		end else if (ch == CH_SEMI) begin
			cmd.cls = CL_SEMI;
		end else if (ch == CH_QUOTE) begin
			cmd.cls = CL_QUOTE;
		end else if (ch >= CH_DIGIT0 && ch <= CH_DIGIT9) begin
			cmd.cls = CL_DIGIT;
		end else if ((ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ||
				(ch >= CH_UPPER_A && ch <= CH_UPPER_Z) || ch == CH_UNDER) begin
			cmd.cls = CL_ALPHA;
		end else begin
			// Operators that may start a two-character form wait for the next one.
			unique case (ch)
				CH_AMP:   begin cmd.cls = CL_LONE;   cmd.op_kind = K_AMP;      end
				CH_BAR:   begin cmd.cls = CL_LONE;   cmd.op_kind = K_BAR;      end
				CH_EQUAL: begin cmd.cls = CL_LONE;   cmd.op_kind = K_ASSIGN;   end
				CH_BANG:  begin cmd.cls = CL_LONE;   cmd.op_kind = K_BANG;     end
				CH_LT:    begin cmd.cls = CL_LONE;   cmd.op_kind = K_LT;       end
				CH_GT:    begin cmd.cls = CL_LONE;   cmd.op_kind = K_GT;       end
				"(":      begin cmd.cls = CL_SINGLE; cmd.op_kind = K_LPAREN;   end
				")":      begin cmd.cls = CL_SINGLE; cmd.op_kind = K_RPAREN;   end
				"[":      begin cmd.cls = CL_SINGLE; cmd.op_kind = K_LBRACKET; end
				"]":      begin cmd.cls = CL_SINGLE; cmd.op_kind = K_RBRACKET; end
				",":      begin cmd.cls = CL_SINGLE; cmd.op_kind = K_COMMA;    end
				"+":      begin cmd.cls = CL_SINGLE; cmd.op_kind = K_PLUS;     end
				"-":      begin cmd.cls = CL_SINGLE; cmd.op_kind = K_MINUS;    end
				"*":      begin cmd.cls = CL_SINGLE; cmd.op_kind = K_STAR;     end
				"/":      begin cmd.cls = CL_SINGLE; cmd.op_kind = K_SLASH;    end
				"%":      begin cmd.cls = CL_SINGLE; cmd.op_kind = K_PERCENT;  end
				"^":      begin cmd.cls = CL_SINGLE; cmd.op_kind = K_CARET;    end
				"~":      begin cmd.cls = CL_SINGLE; cmd.op_kind = K_TILDE;    end
				default:  begin cmd.cls = CL_OTHER;  cmd.op_kind = K_INVALID;  end
			endcase
		end
	end

endmodule

FILE: rtl/stl_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Lexer command queue
// Short queue of classified characters between the front end and the scanner.
// ----------------------------------------------------------------------------
module stl_cmd_fifo import stl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd,
	output cmd_t rd_data,
	output logic empty
);

	cmd_t                    mem_q [CMD_DEPTH];
	logic [CMD_PTR_BITS-1:0] wr_ptr_q;
	logic [CMD_PTR_BITS-1:0] rd_ptr_q;
	logic [CMD_CNT_BITS-1:0] count_q;

	assign full    = (count_q == CMD_CNT_BITS'(CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + CMD_PTR_BITS'(1);
			if (rd) rd_ptr_q <= rd_ptr_q + CMD_PTR_BITS'(1);
			count_q <= count_q + CMD_CNT_BITS'(wr) - CMD_CNT_BITS'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

FILE: rtl/stl_scan.sv
// ----------------------------------------------------------------------------
// Lexer scanner
// Runs the scan state machine, one classified character per cycle while there is room.
// ----------------------------------------------------------------------------
module stl_scan import stl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	input  logic    room,
	output res_wr_t res_wr
);

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_COMMENT = 3'd1;
	localparam logic [2:0] MODE_OPER    = 3'd2;
	localparam logic [2:0] MODE_NUMBER  = 3'd3;
	localparam logic [2:0] MODE_NAME    = 3'd4;
	localparam logic [2:0] MODE_STRING  = 3'd5;

	typedef struct packed {
		logic  v;
		kind_t kind;
		pos_t  start;
		len_t  len;
		logic  sat;
	} emit_t;

	// Keyword text, first character in the low byte, zero padded.
	function automatic logic [WINDOW_BITS-1:0] kw_pattern(input int k);
		logic [63:0]            txt;
		int                     n;
		logic [WINDOW_BITS-1:0] pat;
		txt = '0;
		n   = 0;
		pat = '0;
		unique case (k)
			0:       begin txt = 64'("local");  n = 5; end
			1:       begin txt = 64'("if");     n = 2; end
			2:       begin txt = 64'("then");   n = 4; end
			3:       begin txt = 64'("else");   n = 4; end
			4:       begin txt = 64'("end");    n = 3; end
			5:       begin txt = 64'("while");  n = 5; end
			6:       begin txt = 64'("do");     n = 2; end
			7:       begin txt = 64'("sub");    n = 3; end
			8:       begin txt = 64'("return"); n = 6; end
			9:       begin txt = 64'("byte");   n = 4; end
			default: begin txt = '0;            n = 0; end
		endcase
		for (int i = 0; i < KEYWORD_CHARS; i++) begin
			if (i < n) pat[8*i +: 8] = txt[8*(n-1-i) +: 8];
		end
		return pat;
	endfunction

	logic [2:0]             mode_q,  mode_d;
	pos_t                   pos_q,   pos_d;
	logic [7:0]             pend_ch_q, pend_ch_d;
	kind_t                  pend_kind_q, pend_kind_d;
	pos_t                   start_q, start_d;
	len_t                   len_q,   len_d;
	logic                   over_q,  over_d;
	logic [WINDOW_BITS-1:0] win_q,   win_d;

	logic  go;
	len_t  g_len;
	logic  g_over;
	kind_t name_k;
	logic  pair_hit;
	kind_t pair_k;
	emit_t e0, e1, first;
	logic  do_begin;

	assign go      = cmd_valid & room;
	assign cmd_pop = go;

	// Saturating growth of the open token.
	assign g_over = over_q | (len_q == LEN_MAX);
	assign g_len  = (len_q == LEN_MAX) ? len_q : len_q + LENGTH_BITS'(1);

	always_comb begin
		name_k = K_NAME;
		if (!over_q && len_q <= LENGTH_BITS'(KEYWORD_CHARS)) begin
			for (int k = 0; k < NUM_KEYWORDS; k++) begin
				if (win_q == kw_pattern(k)) name_k = KIND_BITS'(K_KEYWORD0 + k);
			end
		end
	end

	always_comb begin
		pair_hit = 1'b0;
		pair_k   = K_INVALID;
		if (cmd.ch == pend_ch_q) begin
			unique case (pend_ch_q)
				CH_AMP:   begin pair_hit = 1'b1; pair_k = K_AND_AND; end
				CH_BAR:   begin pair_hit = 1'b1; pair_k = K_OR_OR;   end
				CH_EQUAL: begin pair_hit = 1'b1; pair_k = K_EQ_EQ;   end
				CH_LT:    begin pair_hit = 1'b1; pair_k = K_SHL;     end
				CH_GT:    begin pair_hit = 1'b1; pair_k = K_SHR;     end
				default:  begin pair_hit = 1'b0; pair_k = K_INVALID; end
			endcase
		end else if (cmd.ch == CH_EQUAL) begin
			unique case (pend_ch_q)
				CH_BANG:  begin pair_hit = 1'b1; pair_k = K_NOT_EQ;  end
				CH_LT:    begin pair_hit = 1'b1; pair_k = K_LE;      end
				CH_GT:    begin pair_hit = 1'b1; pair_k = K_GE;      end
				default:  begin pair_hit = 1'b0; pair_k = K_INVALID; end
			endcase
		end
	end

	always_comb begin
		mode_d      = mode_q;
		pos_d       = pos_q;
		pend_ch_d   = pend_ch_q;
		pend_kind_d = pend_kind_q;
		start_d     = start_q;
		len_d       = len_q;
		over_d      = over_q;
		win_d       = win_q;
		e0          = '0;
		e1          = '0;
		do_begin    = 1'b0;

		if (cmd.eot) begin
			// Flush the open token, then the end marker, then back to reset.
			unique case (mode_q)
				MODE_OPER:   e0 = {1'b1, pend_kind_q, start_q, LENGTH_BITS'(1), 1'b0};
				MODE_NUMBER: e0 = {1'b1, K_NUMBER, start_q, len_q, over_q};
				MODE_NAME:   e0 = {1'b1, name_k, start_q, len_q, over_q};
				MODE_STRING: e0 = {1'b1, K_INVALID, start_q, len_q, over_q};
				default:     e0 = '0;
			endcase
			e1          = {1'b1, K_END, pos_q, LENGTH_BITS'(0), 1'b0};
			mode_d      = MODE_IDLE;
			pos_d       = '0;
			pend_ch_d   = '0;
			pend_kind_d = '0;
			start_d     = '0;
			len_d       = '0;
			over_d      = 1'b0;
			win_d       = '0;
		end else begin
			pos_d = pos_q + POSITION_BITS'(1);
			unique case (mode_q)
				MODE_COMMENT: begin
					if (cmd.cls == CL_NEWLINE) mode_d = MODE_IDLE;
				end
				MODE_STRING: begin
					len_d  = g_len;
					over_d = g_over;
					if (cmd.cls == CL_QUOTE) begin
						e0     = {1'b1, K_STRING, start_q, g_len, g_over};
						mode_d = MODE_IDLE;
					end
				end
				MODE_NUMBER: begin
					if (cmd.cls == CL_DIGIT) begin
						len_d  = g_len;
						over_d = g_over;
					end else begin
						e0       = {1'b1, K_NUMBER, start_q, len_q, over_q};
						do_begin = 1'b1;
					end
				end
				MODE_NAME: begin
					if (cmd.cls == CL_ALPHA || cmd.cls == CL_DIGIT) begin
						for (int i = 0; i < KEYWORD_CHARS; i++) begin
							if (!over_q && len_q == LENGTH_BITS'(i)) win_d[8*i +: 8] = cmd.ch;
						end
						len_d  = g_len;
						over_d = g_over;
					end else begin
						e0       = {1'b1, name_k, start_q, len_q, over_q};
						do_begin = 1'b1;
					end
				end
				MODE_OPER: begin
					if (pair_hit) begin
						e0     = {1'b1, pair_k, start_q, LENGTH_BITS'(2), 1'b0};
						mode_d = MODE_IDLE;
					end else begin
						e0       = {1'b1, pend_kind_q, start_q, LENGTH_BITS'(1), 1'b0};
						do_begin = 1'b1;
					end
				end
				default: do_begin = 1'b1;
			endcase

			if (do_begin) begin
				mode_d  = MODE_IDLE;
				start_d = pos_q;
				len_d   = LENGTH_BITS'(1);
				over_d  = 1'b0;
				unique case (cmd.cls)
					CL_BLANK, CL_NEWLINE: mode_d = MODE_IDLE;
					CL_SEMI:  mode_d = MODE_COMMENT;
					CL_QUOTE: mode_d = MODE_STRING;
					CL_DIGIT: mode_d = MODE_NUMBER;
					CL_ALPHA: begin
						win_d  = WINDOW_BITS'(cmd.ch);
						mode_d = MODE_NAME;
					end
					CL_LONE: begin
						pend_ch_d   = cmd.ch;
						pend_kind_d = cmd.op_kind;
						mode_d      = MODE_OPER;
					end
					default: e1 = {1'b1, cmd.op_kind, pos_q, LENGTH_BITS'(1), 1'b0};
				endcase
			end
		end
	end

	// Pack the emissions into the result queue, oldest first.
	assign first         = e0.v ? e0 : e1;
	assign res_wr.wr0    = go & (e0.v | e1.v);
	assign res_wr.wr1    = go & e0.v & e1.v;
	assign res_wr.r0     = {first.kind, START_BITS'(first.start),
		OUT_LENGTH_BITS'(first.len), first.sat, ~(e0.v & e1.v)};
	assign res_wr.r1     = {e1.kind, START_BITS'(e1.start),
		OUT_LENGTH_BITS'(e1.len), e1.sat, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			pos_q       <= '0;
			pend_ch_q   <= '0;
			pend_kind_q <= '0;
			start_q     <= '0;
			len_q       <= '0;
			over_q      <= 1'b0;
			win_q       <= '0;
		end else if (go) begin
			mode_q      <= mode_d;
			pos_q       <= pos_d;
			pend_ch_q   <= pend_ch_d;
			pend_kind_q <= pend_kind_d;
			start_q     <= start_d;
			len_q       <= len_d;
			over_q      <= over_d;
			win_q       <= win_d;
		end
	end

endmodule

FILE: rtl/stl_res_fifo.sv
// ----------------------------------------------------------------------------
// Lexer result queue
// Takes up to two results per cycle from the scanner, hands out one per pop.
// ----------------------------------------------------------------------------
module stl_res_fifo import stl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  res_wr_t res_wr,
	output logic    room,
	input  logic    pop,
	output logic    empty,
	output res_t    head
);

	res_t                    mem_q [RES_DEPTH];
	logic [RES_PTR_BITS-1:0] wr_ptr_q;
	logic [RES_PTR_BITS-1:0] rd_ptr_q;
	logic [RES_CNT_BITS-1:0] count_q;
	logic                    rd;

	assign empty = (count_q == '0);
	assign room  = (count_q <= RES_CNT_BITS'(RES_DEPTH - 2));
	assign rd    = pop & ~empty;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PTR_BITS'(res_wr.wr0) + RES_PTR_BITS'(res_wr.wr1);
			if (rd) rd_ptr_q <= rd_ptr_q + RES_PTR_BITS'(1);
			count_q <= count_q + RES_CNT_BITS'(res_wr.wr0) + RES_CNT_BITS'(res_wr.wr1)
				- RES_CNT_BITS'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr.wr0) mem_q[wr_ptr_q] <= res_wr.r0;
		if (res_wr.wr1) mem_q[wr_ptr_q + RES_PTR_BITS'(1)] <= res_wr.r1;
	end

endmodule

FILE: rtl/source_text_lexer.sv
// ----------------------------------------------------------------------------
// Source text lexer
// Streaming tokenizer: one text byte in, tokens out as kind, start and length.
// ----------------------------------------------------------------------------
// The lexer takes one character per clock cycle while not stalled and emits
// tokens (operators, keywords, strings, numbers, identifiers, invalid
// characters and an end marker) as kind, start offset and saturating length.
// A transaction on the input side enters a four-entry command queue; the
// scanner takes one command per cycle while the four-entry result queue has
// two free entries and writes the results it causes, up to two, into that
// queue in the same cycle. The first result of a character passes the command
// queue and the scanner before it is visible on the output. The rate on the
// input side is thus one character per cycle as long as results are popped
// about as fast as they are made; a character that ends one token and starts
// a one-character operator puts two results in the queue and so costs two
// pops. When the command queue fills, full stays high until the consumer pops.
// ----------------------------------------------------------------------------
module source_text_lexer import stl_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [7:0]                 ch,
	input  logic                       end_of_text,
	output logic                       empty,
	input  logic                       pop,
	output logic [KIND_BITS-1:0]       kind,
	output logic [START_BITS-1:0]      start_res,
	output logic [OUT_LENGTH_BITS-1:0] length,
	output logic                       length_saturated,
	output logic                       last
);

	// Front end to command queue.
	logic    cmd_wr;
	cmd_t    cmd_in;
	logic    cmd_full;

	// Command queue to scanner.
	logic    cmd_empty;
	cmd_t    cmd_head;
	logic    cmd_pop;

	// Scanner to result queue.
	res_wr_t res_wr;
	logic    res_room;
	res_t    res_head;

	// The front end only classifies; the handshake follows the command queue.
	stl_front u_front (
		.push        (push),
		.full        (full),
		.ch          (ch),
		.end_of_text (end_of_text),
		.fifo_full   (cmd_full),
		.fifo_wr     (cmd_wr),
		.cmd         (cmd_in)
	);

	stl_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_wr),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd      (cmd_pop),
		.rd_data (cmd_head),
		.empty   (cmd_empty)
	);

	// The scanner holds the whole token state, including the text offset, which
	// returns to zero after each end-of-text marker.
	stl_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (~cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.room      (res_room),
		.res_wr    (res_wr)
	);

	stl_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.res_wr (res_wr),
		.room   (res_room),
		.pop    (pop),
		.empty  (empty),
		.head   (res_head)
	);

	assign kind             = res_head.kind;
	assign start_res        = res_head.start;
	assign length           = res_head.length;
	assign length_saturated = res_head.sat;
	assign last             = res_head.last;

endmodule

FILE: rtl/stl_checker.sv
// ----------------------------------------------------------------------------
// Lexer port checker
// Watches the result side of the lexer for inconsistent tokens.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stl_checker import stl_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       empty,
	input logic                       pop,
	input logic [KIND_BITS-1:0]       kind,
	input logic [START_BITS-1:0]      start_res,
	input logic [OUT_LENGTH_BITS-1:0] length,
	input logic                       length_saturated,
	input logic                       last
);

	// The end marker is empty and always closes the results of its transaction.
	`STL_ASSERT_IMPL(a_end_marker, !empty && kind == K_END, length == 0 && !length_saturated && last, "end marker malformed")

	// A saturated token reports the largest length.
	`STL_ASSERT_IMPL(a_sat_length, !empty && length_saturated, length == OUT_LENGTH_BITS'(LEN_MAX), "saturated length not at maximum")

	// Operators are one or two characters long.
	`STL_ASSERT_IMPL(a_oper_length, !empty && kind < K_KEYWORD0, !length_saturated && (length == 1 || length == 2), "operator length wrong")

	// A result that is not popped stays on the ports.
	`STL_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(kind) && $stable(start_res) && $stable(length), "result changed while stalled")

endmodule

bind source_text_lexer stl_checker u_checker (.*);
